[rtl/iirdf2_pkg.sv]
// Shared constants, types and the product scaling function for the IIR filter.
package iirdf2_pkg;

    // Filter dimensions and fixed-point scaling.
    localparam int ORDER      = 3;
    localparam int SHIFT      = 20;
    localparam int COEF_BITS  = 14;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = DATA_W + COEF_BITS;
    localparam int LSH        = SHIFT - COEF_BITS + 1;
    localparam int LSH_L      = (LSH > 0) ? LSH : 0;
    localparam int LSH_R      = (LSH < 0) ? -LSH : 0;

    // Register bank layout.
    localparam int NUM_REGS   = 7;
    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = REG_IDX_W + 2;
    localparam int APB_DATA_W = 32;

    // Sequencer step counter width.
    localparam int STEP_W     = 3;

    // Register indexes in the bank.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_B3 = 3'd3,
        REG_A1 = 3'd4,
        REG_A2 = 3'd5,
        REG_A3 = 3'd6
    } t_reg_idx;

    // Reset values of the coefficients.
    localparam logic [COEF_BITS-1:0] RST_B0 = COEF_BITS'(1692);
    localparam logic [COEF_BITS-1:0] RST_B1 = COEF_BITS'(4010);
    localparam logic [COEF_BITS-1:0] RST_B2 = COEF_BITS'(2943);
    localparam logic [COEF_BITS-1:0] RST_B3 = COEF_BITS'(625);
    localparam logic [COEF_BITS-1:0] RST_A1 = COEF_BITS'(0);
    localparam logic [COEF_BITS-1:0] RST_A2 = COEF_BITS'(486);
    localparam logic [COEF_BITS-1:0] RST_A3 = COEF_BITS'(593);

    // Coefficient set handed to the datapath.
    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] b3;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
        logic signed [COEF_BITS-1:0] a3;
    } t_coefs;

    // Operand pair selected for the shared multiplier.
    typedef enum logic [2:0] {
        MUL_A1 = 3'd0,
        MUL_A2 = 3'd1,
        MUL_A3 = 3'd2,
        MUL_B1 = 3'd3,
        MUL_B2 = 3'd4,
        MUL_B3 = 3'd5,
        MUL_B0 = 3'd6
    } t_mul_sel;

    // What the accumulators do with the registered product.
    typedef enum logic [2:0] {
        ACC_NONE     = 3'd0,
        ACC_FB_FIRST = 3'd1,
        ACC_FB       = 3'd2,
        ACC_FF_FIRST = 3'd3,
        ACC_FF       = 3'd4,
        ACC_OUT      = 3'd5
    } t_acc_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     x_load;
        logic     mul_en;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     w_load;
        logic     dly_shift;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Shift an exact product right by SHIFT, then left by SHIFT-COEF_BITS+1,
    // keeping the low word.
    function automatic logic [DATA_W-1:0] scale(input logic signed [PROD_W-1:0] prod);
        logic signed [PROD_W-1:0] r;
        r = prod >>> SHIFT;
        if (LSH >= 0) begin
            scale = DATA_W'(r <<< LSH_L);
        end else begin
            scale = DATA_W'(r >>> LSH_R);
        end
    endfunction

endpackage

[rtl/iirdf2_regs.sv]
// APB coefficient register bank of the IIR filter.
module iirdf2_regs (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [iirdf2_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [iirdf2_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [iirdf2_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                  pready,
    output iirdf2_pkg::t_coefs                    o_coefs
);

    iirdf2_pkg::t_coefs                       r_coefs;
    logic [iirdf2_pkg::REG_IDX_W-1:0]         s_idx;
    logic [iirdf2_pkg::COEF_BITS-1:0]         s_wval;
    logic [iirdf2_pkg::COEF_BITS-1:0]         s_rval;
    logic                                     s_wr;

    assign pready  = 1'b1;
    assign s_idx   = paddr[iirdf2_pkg::APB_ADDR_W-1:2];
    assign s_wval  = pwdata[iirdf2_pkg::COEF_BITS-1:0];
    assign s_wr    = psel && penable && pwrite;
    assign o_coefs = r_coefs;

    // Register writes on the access phase; unmapped indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= iirdf2_pkg::RST_B0;
            r_coefs.b1 <= iirdf2_pkg::RST_B1;
            r_coefs.b2 <= iirdf2_pkg::RST_B2;
            r_coefs.b3 <= iirdf2_pkg::RST_B3;
            r_coefs.a1 <= iirdf2_pkg::RST_A1;
            r_coefs.a2 <= iirdf2_pkg::RST_A2;
            r_coefs.a3 <= iirdf2_pkg::RST_A3;
        end else if (s_wr) begin
            case (s_idx)
                iirdf2_pkg::REG_B0: r_coefs.b0 <= s_wval;
                iirdf2_pkg::REG_B1: r_coefs.b1 <= s_wval;
                iirdf2_pkg::REG_B2: r_coefs.b2 <= s_wval;
                iirdf2_pkg::REG_B3: r_coefs.b3 <= s_wval;
                iirdf2_pkg::REG_A1: r_coefs.a1 <= s_wval;
                iirdf2_pkg::REG_A2: r_coefs.a2 <= s_wval;
                iirdf2_pkg::REG_A3: r_coefs.a3 <= s_wval;
                default: ;
            endcase
        end
    end

    // Read mux; unmapped indexes read as zero.
    always_comb begin
        case (s_idx)
            iirdf2_pkg::REG_B0: s_rval = r_coefs.b0;
            iirdf2_pkg::REG_B1: s_rval = r_coefs.b1;
            iirdf2_pkg::REG_B2: s_rval = r_coefs.b2;
            iirdf2_pkg::REG_B3: s_rval = r_coefs.b3;
            iirdf2_pkg::REG_A1: s_rval = r_coefs.a1;
            iirdf2_pkg::REG_A2: s_rval = r_coefs.a2;
            iirdf2_pkg::REG_A3: s_rval = r_coefs.a3;
            default:            s_rval = '0;
        endcase
    end

    assign prdata = iirdf2_pkg::APB_DATA_W'(s_rval);

endmodule

[rtl/iirdf2_dp.sv]
// Datapath of the IIR filter: shared multiplier, accumulators, delay line, output register.
module iirdf2_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  iirdf2_pkg::t_dp_cmd                   i_cmd,
    output iirdf2_pkg::t_dp_status                o_status,
    input  iirdf2_pkg::t_coefs                    i_coefs,
    input  logic signed [iirdf2_pkg::DATA_W-1:0]  i_sample_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [iirdf2_pkg::DATA_W-1:0]  o_sample_out
);

    logic        [iirdf2_pkg::DATA_W-1:0]     r_delay [iirdf2_pkg::ORDER];
    logic        [iirdf2_pkg::DATA_W-1:0]     r_x;
    logic        [iirdf2_pkg::DATA_W-1:0]     r_w;
    logic        [iirdf2_pkg::DATA_W-1:0]     r_fb;
    logic        [iirdf2_pkg::DATA_W-1:0]     r_ff;
    logic        [iirdf2_pkg::DATA_W-1:0]     r_out;
    logic                                     r_out_valid;
    logic signed [iirdf2_pkg::PROD_W-1:0]     r_prod;
    logic signed [iirdf2_pkg::PROD_W-1:0]     n_prod;
    logic signed [iirdf2_pkg::DATA_W-1:0]     s_opd;
    logic signed [iirdf2_pkg::COEF_BITS-1:0]  s_opc;
    logic        [iirdf2_pkg::DATA_W-1:0]     s_scaled;

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_cmd.mul_sel)
            iirdf2_pkg::MUL_A1: begin s_opd = r_delay[0]; s_opc = i_coefs.a1; end
            iirdf2_pkg::MUL_A2: begin s_opd = r_delay[1]; s_opc = i_coefs.a2; end
            iirdf2_pkg::MUL_A3: begin s_opd = r_delay[2]; s_opc = i_coefs.a3; end
            iirdf2_pkg::MUL_B1: begin s_opd = r_delay[0]; s_opc = i_coefs.b1; end
            iirdf2_pkg::MUL_B2: begin s_opd = r_delay[1]; s_opc = i_coefs.b2; end
            iirdf2_pkg::MUL_B3: begin s_opd = r_delay[2]; s_opc = i_coefs.b3; end
            iirdf2_pkg::MUL_B0: begin s_opd = r_w;        s_opc = i_coefs.b0; end
            default:            begin s_opd = r_w;        s_opc = i_coefs.b0; end
        endcase
    end

    // Exact signed product, registered before scaling.
    assign n_prod = s_opd * s_opc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
    end

    assign s_scaled = iirdf2_pkg::scale(r_prod);

    // Input sample capture and the intermediate value w = x + feedback.
    always_ff @(posedge i_clk) begin
        if (i_cmd.x_load) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.w_load) begin
            r_w <= r_x + r_fb;
        end
    end

    // Feedback and feed-forward accumulators and the output register, wrapping at the word width.
    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            iirdf2_pkg::ACC_FB_FIRST: r_fb  <= '0 - s_scaled;
            iirdf2_pkg::ACC_FB:       r_fb  <= r_fb - s_scaled;
            iirdf2_pkg::ACC_FF_FIRST: r_ff  <= s_scaled;
            iirdf2_pkg::ACC_FF:       r_ff  <= r_ff + s_scaled;
            iirdf2_pkg::ACC_OUT:      r_out <= r_ff + s_scaled;
            default: ;
        endcase
    end

    // Delay line of intermediate values, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < iirdf2_pkg::ORDER; k++) begin
                r_delay[k] <= '0;
            end
        end else if (i_cmd.dly_shift) begin
            r_delay[0] <= r_w;
            for (int k = 1; k < iirdf2_pkg::ORDER; k++) begin
                r_delay[k] <= r_delay[k-1];
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.acc_op == iirdf2_pkg::ACC_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_sample_out      = r_out;

endmodule

[rtl/iirdf2_ctrl.sv]
// Sequencer of the IIR filter: schedules the seven products on the shared multiplier.
module iirdf2_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  iirdf2_pkg::t_dp_status i_status,
    output iirdf2_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    // Steps of one transaction after the accept cycle.
    localparam logic [iirdf2_pkg::STEP_W-1:0] STEP_A2  = 3'd1;
    localparam logic [iirdf2_pkg::STEP_W-1:0] STEP_A3  = 3'd2;
    localparam logic [iirdf2_pkg::STEP_W-1:0] STEP_B1  = 3'd3;
    localparam logic [iirdf2_pkg::STEP_W-1:0] STEP_B2  = 3'd4;
    localparam logic [iirdf2_pkg::STEP_W-1:0] STEP_B3  = 3'd5;
    localparam logic [iirdf2_pkg::STEP_W-1:0] STEP_B0  = 3'd6;
    localparam logic [iirdf2_pkg::STEP_W-1:0] STEP_OUT = 3'd7;

    t_state                          r_state;
    t_state                          n_state;
    logic [iirdf2_pkg::STEP_W-1:0]   r_step;
    logic [iirdf2_pkg::STEP_W-1:0]   n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        o_in_ready      = 1'b0;
        o_cmd.x_load    = 1'b0;
        o_cmd.mul_en    = 1'b0;
        o_cmd.mul_sel   = iirdf2_pkg::MUL_A1;
        o_cmd.acc_op    = iirdf2_pkg::ACC_NONE;
        o_cmd.w_load    = 1'b0;
        o_cmd.dly_shift = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    // The first feedback product starts in the accept cycle.
                    o_cmd.x_load  = 1'b1;
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = iirdf2_pkg::MUL_A1;
                    n_state       = ST_RUN;
                    n_step        = STEP_A2;
                end
            end
            ST_RUN: begin
                n_step = r_step + 1'b1;
                case (r_step)
                    STEP_A2: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = iirdf2_pkg::MUL_A2;
                        o_cmd.acc_op  = iirdf2_pkg::ACC_FB_FIRST;
                    end
                    STEP_A3: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = iirdf2_pkg::MUL_A3;
                        o_cmd.acc_op  = iirdf2_pkg::ACC_FB;
                    end
                    STEP_B1: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = iirdf2_pkg::MUL_B1;
                        o_cmd.acc_op  = iirdf2_pkg::ACC_FB;
                    end
                    STEP_B2: begin
                        // Feedback is complete here, so w is formed now.
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = iirdf2_pkg::MUL_B2;
                        o_cmd.acc_op  = iirdf2_pkg::ACC_FF_FIRST;
                        o_cmd.w_load  = 1'b1;
                    end
                    STEP_B3: begin
                        o_cmd.mul_en  = 1'b1;
                        o_cmd.mul_sel = iirdf2_pkg::MUL_B3;
                        o_cmd.acc_op  = iirdf2_pkg::ACC_FF;
                    end
                    STEP_B0: begin
                        // The taps are no longer needed, so the delay line moves.
                        o_cmd.mul_en    = 1'b1;
                        o_cmd.mul_sel   = iirdf2_pkg::MUL_B0;
                        o_cmd.acc_op    = iirdf2_pkg::ACC_FF;
                        o_cmd.dly_shift = 1'b1;
                    end
                    STEP_OUT: begin
                        // Wait here while the previous result is still held.
                        n_step = r_step;
                        if (i_status.out_free) begin
                            o_cmd.acc_op = iirdf2_pkg::ACC_OUT;
                            n_state      = ST_IDLE;
                            n_step       = '0;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                        n_step  = '0;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

endmodule

[rtl/iir_filter_direct_form2_fixed.sv]
// Top level of the third-order direct form II fixed-point IIR filter.
//
// Input samples arrive on a valid/ready channel (i_in_valid, o_in_ready,
// i_sample_in) and filtered samples leave on another (o_out_valid,
// i_out_ready, o_sample_out); one result follows every input transaction.
// The seven coefficients are written through an APB port at byte addresses
// 0, 4, ... 24 in the order b0, b1, b2, b3, a1, a2, a3; pready is always high.
// A single multiplier computes all seven products in sequence, so one sample
// occupies the block for the accept cycle plus seven sequencer steps. The
// result is registered in the last step, and a new sample can be accepted in
// the cycle after that. The result sits in an output register, so the next
// sample is accepted while a result still waits; if the receiver stalls, the
// following result is held in the last step until the output register frees
// up. Synchronous reset clears the delay line, restores the default
// coefficients and empties the output register. The user must write
// coefficients only while idle; the block itself does not enforce this.
module iir_filter_direct_form2_fixed (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [iirdf2_pkg::DATA_W-1:0]  i_sample_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [iirdf2_pkg::DATA_W-1:0]  o_sample_out,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [iirdf2_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [iirdf2_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [iirdf2_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                  pready
);

    iirdf2_pkg::t_coefs     s_coefs;
    iirdf2_pkg::t_dp_cmd    s_cmd;
    iirdf2_pkg::t_dp_status s_status;

    // Coefficient registers.
    iirdf2_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (s_coefs)
    );

    // Sequencer.
    iirdf2_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (s_status),
        .o_cmd      (s_cmd)
    );

    // Arithmetic and storage.
    iirdf2_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .o_status     (s_status),
        .i_coefs      (s_coefs),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out)
    );

    // The block is busy in the cycle after an input transaction.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while a sample was in progress");

    // A result is only written into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.acc_op == iirdf2_pkg::ACC_OUT |-> (!o_out_valid || i_out_ready))
        else $error("pending result overwritten");

    // Results are produced only while a sample is in progress.
    a_out_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.acc_op == iirdf2_pkg::ACC_OUT |-> !o_in_ready)
        else $error("result produced while idle");

    // Every result written appears on the output the cycle after.
    a_out_valid_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.acc_op == iirdf2_pkg::ACC_OUT |=> o_out_valid)
        else $error("result not presented");

endmodule

[test/testbench.sv]
// Self-checking testbench for the third-order direct form II fixed-point IIR filter.
`timescale 1ns / 1ps

module testbench;
    import iirdf2_pkg::*;

    // Register index past the end of the coefficient bank; writes to it are dropped.
    localparam int UNMAPPED_IDX = NUM_REGS;

    // Coefficient sets that a configuration phase can load.
    typedef enum int {
        COEFS_DEFAULT,
        COEFS_MIN,
        COEFS_MAX,
        COEFS_ALTERNATING,
        COEFS_RANDOM,
        COEFS_SMALL
    } t_coef_set;

    // One row of the directed sample table; known rows carry a hand-computed output.
    typedef struct packed {
        logic [DATA_W-1:0] sample;
        logic              known;
        logic [DATA_W-1:0] result;
    } t_probe;

    localparam int NUM_PROBES = 14;

    // The first three rows run in turn from a cleared delay line and the reset coefficients.
    localparam t_probe PROBES [NUM_PROBES] = '{
        '{32'h0000_0000, 1'b1, 32'h0000_0000},
        '{32'h8000_0000, 1'b1, -32'sd443547648},
        '{32'h0000_0000, 1'b1, -32'sd1051197440},
        '{32'h0000_0000, 1'b0, 32'h0},
        '{32'h7FFF_FFFF, 1'b0, 32'h0},
        '{32'h7FFF_FFFF, 1'b0, 32'h0},
        '{32'hFFFF_FFFF, 1'b0, 32'h0},
        '{32'h0000_0001, 1'b0, 32'h0},
        '{32'h5555_5555, 1'b0, 32'h0},
        '{32'hAAAA_AAAA, 1'b0, 32'h0},
        '{32'h8000_0000, 1'b0, 32'h0},
        '{32'h0000_0000, 1'b0, 32'h0},
        '{32'h0000_0000, 1'b0, 32'h0},
        '{32'h0000_0000, 1'b0, 32'h0}
    };

    localparam int NUM_PHASES       = 12;
    localparam int SAMPLES_PER_PHASE = 150;
    localparam int DRAIN_CYCLES     = 20;

    logic                    i_clk;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic                    o_in_ready;
    logic signed [DATA_W-1:0] i_sample_in = '0;
    logic                    o_out_valid;
    logic                    i_out_ready  = 1'b0;
    logic signed [DATA_W-1:0] o_sample_out;
    logic                    psel         = 1'b0;
    logic                    penable      = 1'b0;
    logic                    pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr        = '0;
    logic [APB_DATA_W-1:0]   pwdata       = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // Predictor state: coefficient bank and delayed intermediate values.
    logic signed [COEF_BITS-1:0] coef_bank [NUM_REGS];
    logic [DATA_W-1:0]           w_hist [ORDER];

    // Filtered samples predicted but not yet received, oldest first.
    logic [DATA_W-1:0] pending_outputs [$];

    int mismatch_count = 0;
    bit sender_idles   = 1'b1;
    bit receiver_idles = 1'b1;

    iir_filter_direct_form2_fixed DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Free-running clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on the run in case the block hangs.
    initial begin
        #1_000_000;
        $display("iir_filter_direct_form2_fixed regression: fail");
        $finish;
    end

    function automatic logic [COEF_BITS-1:0] default_coef(input int idx);
        case (t_reg_idx'(idx))
            REG_B0: return RST_B0;
            REG_B1: return RST_B1;
            REG_B2: return RST_B2;
            REG_B3: return RST_B3;
            REG_A1: return RST_A1;
            REG_A2: return RST_A2;
            default: return RST_A3;
        endcase
    endfunction

    // Drop the low SHIFT bits of an exact product, then rescale and keep the low word.
    function automatic logic [DATA_W-1:0] rescale_product(input longint prod);
        longint r;
        r = prod >>> SHIFT;
        if (LSH >= 0) begin
            return DATA_W'(r <<< LSH_L);
        end
        return DATA_W'(r >>> LSH_R);
    endfunction

    // Compute the filtered sample for one input and advance the delay line.
    function automatic logic [DATA_W-1:0] next_filter_output(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] fb;
        logic [DATA_W-1:0] ff;
        logic [DATA_W-1:0] w;
        longint            d;
        fb = '0;
        ff = '0;
        // Taps past the third carry no coefficient.
        for (int k = 0; k < ORDER && k < 3; k++) begin
            d  = longint'($signed(w_hist[k]));
            fb = fb - rescale_product(d * longint'(coef_bank[int'(REG_A1) + k]));
            ff = ff + rescale_product(d * longint'(coef_bank[int'(REG_B1) + k]));
        end
        w = x + fb;
        for (int k = ORDER - 1; k > 0; k--) begin
            w_hist[k] = w_hist[k - 1];
        end
        w_hist[0] = w;
        return rescale_product(longint'($signed(w)) * longint'(coef_bank[REG_B0])) + ff;
    endfunction

    // APB write: setup cycle, then access cycle until pready. Called at a clock edge.
    task automatic write_coef(input int idx, input logic [APB_DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        // Only the low coefficient bits are kept, and unmapped indexes are dropped.
        if (idx < NUM_REGS) begin
            coef_bank[idx] = value[COEF_BITS-1:0];
        end
    endtask

    // Load a full coefficient set with junk in the unused upper data bits.
    task automatic program_coefs(input t_coef_set set);
        logic [APB_DATA_W-1:0] value;
        logic [COEF_BITS-1:0]  c;
        int                    small_val;
        for (int i = 0; i < NUM_REGS; i++) begin
            small_val = int'($urandom_range(0, 2047)) - 1024;
            case (set)
                COEFS_DEFAULT:     c = default_coef(i);
                COEFS_MIN:         c = {1'b1, {(COEF_BITS-1){1'b0}}};
                COEFS_MAX:         c = {1'b0, {(COEF_BITS-1){1'b1}}};
                COEFS_ALTERNATING: c = (i % 2 == 0) ? {1'b0, {(COEF_BITS-1){1'b1}}}
                                                    : {1'b1, {(COEF_BITS-1){1'b0}}};
                COEFS_RANDOM:      c = COEF_BITS'($urandom());
                default:           c = (i == int'(REG_A1)) ? '0 : small_val[COEF_BITS-1:0];
            endcase
            value = $urandom();
            value[COEF_BITS-1:0] = c;
            write_coef(i, value);
        end
        write_coef(UNMAPPED_IDX, $urandom());
    endtask

    // Offer one sample, hold it until the transaction completes, and predict its output.
    task automatic send_sample(input logic [DATA_W-1:0] x, input bit known,
                               input logic [DATA_W-1:0] typed);
        int                gap;
        logic [DATA_W-1:0] predicted;
        gap = sender_idles ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = next_filter_output(x);
        pending_outputs.push_back(known ? typed : predicted);
    endtask

    // Stop offering samples and let every pending output come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] random_sample();
        int small_val;
        small_val = int'($urandom_range(0, 2047)) - 1024;
        case ($urandom_range(0, 7))
            0: return DATA_W'(small_val);
            1: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0000_0001;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // Receiver: random back-pressure, and each output transaction checked in order.
    initial begin
        int                stall;
        logic [DATA_W-1:0] want;
        wait (i_rst_n);
        forever begin
            stall = receiver_idles ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (pending_outputs.size() == 0) begin
                $display("%0t: sample_out %0d arrived with no result pending",
                         $time, o_sample_out);
                mismatch_count++;
            end else begin
                want = pending_outputs.pop_front();
                if (o_sample_out !== want) begin
                    $display("%0t: sample_out mismatch, expected %0d, got %0d",
                             $time, $signed(want), o_sample_out);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed samples, extreme coefficients, random phases.
    initial begin
        for (int i = 0; i < NUM_REGS; i++) begin
            coef_bank[i] = default_coef(i);
        end
        for (int k = 0; k < ORDER; k++) begin
            w_hist[k] = '0;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table on the reset coefficients.
        for (int n = 0; n < NUM_PROBES; n++) begin
            send_sample(PROBES[n].sample, PROBES[n].known, PROBES[n].result);
        end

        // Full-scale coefficient sets driven with full-scale samples.
        for (int s = int'(COEFS_MIN); s <= int'(COEFS_ALTERNATING); s++) begin
            wait_drained();
            program_coefs(t_coef_set'(s));
            send_sample(32'h8000_0000, 1'b0, '0);
            send_sample(32'h7FFF_FFFF, 1'b0, '0);
            send_sample(32'h8000_0000, 1'b0, '0);
            send_sample(32'h0000_0000, 1'b0, '0);
        end

        // Random phases, each with its own coefficient set and idling pattern.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            program_coefs(t_coef_set'(phase % 6));
            sender_idles   = (phase % 3 != 0);
            receiver_idles = (phase % 4 != 1);
            for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
                send_sample(random_sample(), 1'b0, '0);
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("iir_filter_direct_form2_fixed regression: pass");
        end else begin
            $display("iir_filter_direct_form2_fixed regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/iirdf2_pkg.sv
rtl/iirdf2_regs.sv
rtl/iirdf2_dp.sv
rtl/iirdf2_ctrl.sv
rtl/iir_filter_direct_form2_fixed.sv
test/testbench.sv
